FILE: rtl/vbaf_pkg.sv
// Package for the valid-region box average filter.
// Holds sizes, register indexes and the sequencer state type.
// No dependencies.
package vbaf_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxWindow   = 8;
  localparam int unsigned HeightLimit = 1024;
  localparam int unsigned StoreRows   = MaxWindow - 1;

  localparam int unsigned PixW     = 8;
  localparam int unsigned WinRegW  = 4;
  localparam int unsigned DimRegW  = 11;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned SlotW   = (StoreRows > 1) ? $clog2(StoreRows) : 1;
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned WidW    = $clog2(MaxWidth + 1);
  localparam int unsigned WinW    = $clog2(MaxWindow + 1);
  localparam int unsigned IdxW    = $clog2(MaxWindow);
  localparam int unsigned RowW    = $clog2(HeightLimit);
  localparam int unsigned HgtW    = $clog2(HeightLimit + 1);
  localparam int unsigned ColSumW = PixW + $clog2(MaxWindow);
  localparam int unsigned AreaW   = $clog2(MaxWindow * MaxWindow + 1);
  localparam int unsigned SumW    = PixW + $clog2(MaxWindow * MaxWindow);
  localparam int unsigned DivW    = SumW + 1;
  localparam int unsigned StepW   = $clog2(PixW);

  localparam logic [CfgIdxW-1:0] CfgWinRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWinCols = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImgW    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgImgH    = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StShift,
    StSum,
    StDiv,
    StPut
  } state_e;

endpackage

FILE: rtl/valid_box_average_filter_top.sv
// Valid-region box average filter: line memory, column sums and a serial divider.
// Depends on vbaf_pkg.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid_i / in_stall_o   | pixel_i
//  output   | out_valid_o / out_stall_i | average_o, last_o
//  config   | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Once its row fills the window, a pixel reads m - 1 earlier rows (m > 1)
// from the single-port line memory; it is then stored and shifted into the
// column sums. A pixel with a result adds an n-step window sum, an 8-step
// restoring divider and one output load. A result that waits on out_stall_i
// holds the block in its last step until the output register frees up.
// Reset clears the position counters, the sequencer and the output valid flag;
// the line memory is not cleared and needs no clearing pass.
module valid_box_average_filter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vbaf_pkg::PixW-1:0]     pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vbaf_pkg::PixW-1:0]     average_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [vbaf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vbaf_pkg::CfgDataW-1:0] cfg_data_i
);
  import vbaf_pkg::*;

  function automatic logic [WinW-1:0] clamp_win(input logic [WinRegW-1:0] v);
    logic [WinW-1:0] r;
    if (v == '0) r = WinW'(1);
    else if (v > MaxWindow) r = WinW'(MaxWindow);
    else r = WinW'(v);
    return r;
  endfunction

  function automatic logic [WidW-1:0] clamp_wid(input logic [DimRegW-1:0] v);
    logic [WidW-1:0] r;
    if (v == '0) r = WidW'(1);
    else if (v > MaxWidth) r = WidW'(MaxWidth);
    else r = WidW'(v);
    return r;
  endfunction

  function automatic logic [HgtW-1:0] clamp_hgt(input logic [DimRegW-1:0] v);
    logic [HgtW-1:0] r;
    if (v == '0) r = HgtW'(1);
    else if (v > HeightLimit) r = HgtW'(HeightLimit);
    else r = HgtW'(v);
    return r;
  endfunction

  function automatic logic [SlotW-1:0] slot_prev(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == '0) r = SlotW'(StoreRows - 1);
    else r = s - SlotW'(1);
    return r;
  endfunction

  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(StoreRows - 1)) r = '0;
    else r = s + SlotW'(1);
    return r;
  endfunction

  // Configuration and frame position
  logic [WinRegW-1:0] win_rows_q, win_rows_d, win_cols_q, win_cols_d;
  logic [DimRegW-1:0] img_w_q, img_w_d, img_h_q, img_h_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [SlotW-1:0]   slot_q, slot_d;

  // Sequencer
  state_e state_q, state_d;
  logic   rvalid_q;
  logic   rd_en, wr_en, load_out;
  logic [IdxW-1:0] iss_q, iss_d, nrd_q, nrd_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [StepW-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  // Item payload
  logic [PixW-1:0]    pix_q, pix_d;
  logic [ColW-1:0]    icol_q, icol_d;
  logic [SlotW-1:0]   islot_q, islot_d, rd_slot_q, rd_slot_d;
  logic               emit_q, emit_d, ilast_q, ilast_d;
  logic [ColSumW-1:0] colsum_q, colsum_d;
  logic [ColSumW-1:0] recent_q [MaxWindow];
  logic [ColSumW-1:0] recent_d [MaxWindow];
  logic [SumW-1:0]    acc_q, acc_d;
  logic [DivW-1:0]    rem_q, rem_d, dsh_q, dsh_d;
  logic [PixW-1:0]    quot_q, quot_d, avg_q, avg_d;
  logic               last_q, last_d;

  // Line memory
  logic [PixW-1:0] line_mem [StoreRows][MaxWidth];
  logic [PixW-1:0] rdata_q;

  logic [WinW-1:0]  m_c, n_c;
  logic [WidW-1:0]  w_c, col_p1;
  logic [HgtW-1:0]  h_c, row_p1;
  logic [AreaW-1:0] area;
  logic             in_accept, row_fit, col_fit;

  assign m_c    = clamp_win(win_rows_q);
  assign n_c    = clamp_win(win_cols_q);
  assign w_c    = clamp_wid(img_w_q);
  assign h_c    = clamp_hgt(img_h_q);
  assign area   = AreaW'(m_c) * AreaW'(n_c);
  assign row_p1 = HgtW'(row_q) + HgtW'(1);
  assign col_p1 = WidW'(col_q) + WidW'(1);
  assign row_fit = row_p1 >= HgtW'(m_c);
  assign col_fit = col_p1 >= WidW'(n_c);

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign average_o   = avg_q;
  assign last_o      = last_q;

  always_comb begin
    state_d    = state_q;
    win_rows_d = win_rows_q;
    win_cols_d = win_cols_q;
    img_w_d    = img_w_q;
    img_h_d    = img_h_q;
    row_d      = row_q;
    col_d      = col_q;
    slot_d     = slot_q;
    iss_d      = iss_q;
    nrd_d      = nrd_q;
    j_d        = j_q;
    step_d     = step_q;
    pix_d      = pix_q;
    icol_d     = icol_q;
    islot_d    = islot_q;
    rd_slot_d  = rd_slot_q;
    emit_d     = emit_q;
    ilast_d    = ilast_q;
    colsum_d   = colsum_q;
    recent_d   = recent_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    dsh_d      = dsh_q;
    quot_d     = quot_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;

    // Read data lands in the cycle after the read was issued.
    if (rvalid_q) begin
      colsum_d = colsum_q + ColSumW'(rdata_q);
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          pix_d     = pixel_i;
          icol_d    = col_q;
          islot_d   = slot_q;
          rd_slot_d = slot_prev(slot_q);
          nrd_d     = row_fit ? IdxW'(m_c - WinW'(1)) : '0;
          iss_d     = '0;
          colsum_d  = ColSumW'(pixel_i);
          emit_d    = row_fit && col_fit && (HgtW'(m_c) <= h_c) && (WidW'(n_c) <= w_c);
          ilast_d   = (row_p1 == h_c) && (col_p1 == w_c);
          if (col_p1 >= w_c) begin
            col_d = '0;
            if (row_p1 >= h_c) begin
              row_d  = '0;
              slot_d = '0;
            end else begin
              row_d  = row_q + RowW'(1);
              slot_d = slot_next(slot_q);
            end
          end else begin
            col_d = col_q + ColW'(1);
          end
          state_d = StRead;
        end
      end
      StRead: begin
        if (iss_q != nrd_q) begin
          rd_en     = 1'b1;
          iss_d     = iss_q + IdxW'(1);
          rd_slot_d = slot_prev(rd_slot_q);
        end else if (!rvalid_q) begin
          state_d = StShift;
        end
      end
      StShift: begin
        // The current pixel goes to the line memory only after all reads,
        // since the oldest row may share its slot.
        wr_en = 1'b1;
        for (int i = MaxWindow - 1; i > 0; i--) begin
          recent_d[i] = recent_q[i-1];
        end
        recent_d[0] = colsum_q;
        acc_d   = '0;
        j_d     = '0;
        state_d = emit_q ? StSum : StIdle;
      end
      StSum: begin
        if (j_q == IdxW'(n_c - WinW'(1))) begin
          rem_d   = DivW'(acc_q) + DivW'(recent_q[j_q]);
          dsh_d   = DivW'(area) << (PixW - 1);
          quot_d  = '0;
          step_d  = '0;
          state_d = StDiv;
        end else begin
          acc_d = acc_q + SumW'(recent_q[j_q]);
          j_d   = j_q + IdxW'(1);
        end
      end
      StDiv: begin
        if (rem_q >= dsh_q) begin
          rem_d  = rem_q - dsh_q;
          quot_d = {quot_q[PixW-2:0], 1'b1};
        end else begin
          quot_d = {quot_q[PixW-2:0], 1'b0};
        end
        dsh_d  = dsh_q >> 1;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(PixW - 1)) begin
          state_d = StPut;
        end
      end
      StPut: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // A register write restarts the frame.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWinRows: win_rows_d = cfg_data_i[WinRegW-1:0];
        CfgWinCols: win_cols_d = cfg_data_i[WinRegW-1:0];
        CfgImgW:    img_w_d    = cfg_data_i[DimRegW-1:0];
        CfgImgH:    img_h_d    = cfg_data_i[DimRegW-1:0];
        default:    win_rows_d = win_rows_q;
      endcase
      row_d  = '0;
      col_d  = '0;
      slot_d = '0;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
      avg_d       = quot_q;
      last_d      = ilast_q;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
      avg_d       = avg_q;
      last_d      = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      win_rows_q  <= WinRegW'(3);
      win_cols_q  <= WinRegW'(3);
      img_w_q     <= DimRegW'(1024);
      img_h_q     <= DimRegW'(1024);
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= '0;
      iss_q       <= '0;
      nrd_q       <= '0;
      j_q         <= '0;
      step_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_rows_q  <= win_rows_d;
      win_cols_q  <= win_cols_d;
      img_w_q     <= img_w_d;
      img_h_q     <= img_h_d;
      row_q       <= row_d;
      col_q       <= col_d;
      slot_q      <= slot_d;
      iss_q       <= iss_d;
      nrd_q       <= nrd_d;
      j_q         <= j_d;
      step_q      <= step_d;
      rvalid_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    icol_q    <= icol_d;
    islot_q   <= islot_d;
    rd_slot_q <= rd_slot_d;
    emit_q    <= emit_d;
    ilast_q   <= ilast_d;
    colsum_q  <= colsum_d;
    recent_q  <= recent_d;
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    quot_q    <= quot_d;
    avg_q     <= avg_d;
    last_q    <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[islot_q][icol_q] <= pix_q;
    end
    if (rd_en) begin
      rdata_q <= line_mem[rd_slot_q][icol_q];
    end
  end

  // Read data only comes back while the column sum is being gathered.
  a_rvalid_in_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == StRead))
    else $error("line memory data returned outside the read phase");

  // The restoring divider keeps its partial remainder below twice the shifted divisor.
  a_div_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> ({1'b0, rem_q} < {dsh_q, 1'b0}))
    else $error("divider remainder out of range");

  // The column position stays inside the configured image width, the line slot inside the memory.
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WidW'(col_q) < w_c) && (slot_q < SlotW'(StoreRows)))
    else $error("column or line slot position out of range");

  // A finished result waits while the output register is still held.
  a_put_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPut && out_valid_q && out_stall_i) |=> (state_q == StPut))
    else $error("result dropped while output was stalled");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the valid-region box average filter.
// Drives pixel transfers and register writes and checks every average against plan or predictor.
// Depends on vbaf_pkg and valid_box_average_filter_top.
`timescale 1ns / 100ps

module tb;
  import vbaf_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandPixels  = 750;

  typedef struct packed {
    logic [PixW-1:0] average;
    logic            last;
  } mean_t;

  typedef enum logic [1:0] {
    RowCfg,
    RowPix,
    RowPixExp
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [PixW-1:0]      pix;
    logic [PixW-1:0]      avg;
    logic                 lst;
  } plan_row_t;

  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    return '{RowCfg, idx, data, 8'd0, 8'd0, 1'b0};
  endfunction

  function automatic plan_row_t pix_row(logic [PixW-1:0] pix);
    return '{RowPix, 2'd0, 11'd0, pix, 8'd0, 1'b0};
  endfunction

  function automatic plan_row_t exp_row(logic [PixW-1:0] pix, logic [PixW-1:0] avg, logic lst);
    return '{RowPixExp, 2'd0, 11'd0, pix, avg, lst};
  endfunction

  localparam int PlanLen = 50;
  localparam plan_row_t Plan [PlanLen] = '{
    // Reset setting, 3x3 window on a 1024x1024 image: nothing yet.
    pix_row(8'd17), pix_row(8'd200),
    cfg_row(CfgWinRows, 11'd1), cfg_row(CfgWinCols, 11'd1),
    cfg_row(CfgImgW, 11'd1), cfg_row(CfgImgH, 11'd1),
    exp_row(8'd0, 8'd0, 1'b1), exp_row(8'd255, 8'd255, 1'b1),
    // A window size of zero counts as one.
    cfg_row(CfgWinRows, 11'd0), cfg_row(CfgWinCols, 11'd0),
    exp_row(8'h5a, 8'h5a, 1'b1),
    // An image size of zero counts as one.
    cfg_row(CfgImgW, 11'd0), cfg_row(CfgImgH, 11'd0),
    exp_row(8'd7, 8'd7, 1'b1),
    // Window taller than the image.
    cfg_row(CfgWinRows, 11'd2),
    pix_row(8'd9), pix_row(8'd200),
    cfg_row(CfgWinCols, 11'd2), cfg_row(CfgImgW, 11'd2), cfg_row(CfgImgH, 11'd2),
    pix_row(8'd255), pix_row(8'd255), pix_row(8'd255),
    exp_row(8'd255, 8'd255, 1'b1),
    cfg_row(CfgWinRows, 11'd1), cfg_row(CfgWinCols, 11'd3),
    cfg_row(CfgImgW, 11'd3), cfg_row(CfgImgH, 11'd1),
    pix_row(8'd1), pix_row(8'd2),
    exp_row(8'd4, 8'd2, 1'b1),
    cfg_row(CfgWinRows, 11'd2), cfg_row(CfgWinCols, 11'd1),
    cfg_row(CfgImgW, 11'd2), cfg_row(CfgImgH, 11'd2),
    pix_row(8'd99),
    // A write in the middle of a frame starts the frame over.
    cfg_row(CfgImgH, 11'd2),
    pix_row(8'd10), pix_row(8'd20),
    exp_row(8'd30, 8'd20, 1'b0), exp_row(8'd41, 8'd30, 1'b1),
    // Window codes above the maximum count as the maximum: 8x8 on 2x2 gives nothing.
    cfg_row(CfgWinRows, 11'd15), cfg_row(CfgWinCols, 11'd15),
    pix_row(8'd0),
    // Oversized image codes count as 1024.
    cfg_row(CfgWinRows, 11'd1), cfg_row(CfgWinCols, 11'd2),
    cfg_row(CfgImgW, 11'd2047), cfg_row(CfgImgH, 11'd2047),
    pix_row(8'd255),
    exp_row(8'd254, 8'd254, 1'b0)
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     average_o;
  logic                last_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  valid_box_average_filter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state, mirroring the block.
  logic [WinRegW-1:0] win_rows_q = 4'd3;
  logic [WinRegW-1:0] win_cols_q = 4'd3;
  logic [DimRegW-1:0] img_w_q    = 11'd1024;
  logic [DimRegW-1:0] img_h_q    = 11'd1024;
  logic [PixW-1:0]    line_mem [StoreRows][MaxWidth];
  int unsigned        col_sums [MaxWindow] = '{default: 0};
  int unsigned        row_pos = 0;
  int unsigned        col_pos = 0;

  mean_t       pending_means [$];
  int unsigned fault_count   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned means_checked = 0;
  int unsigned reg_writes    = 0;
  int unsigned setups        = 0;
  int unsigned in_gap_max    = 15;
  int unsigned out_wait_max  = 15;
  int unsigned wait_left     = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic mean_filter_step(input logic [PixW-1:0] pix, output bit got, output mean_t res);
    int unsigned m, n, w, h, colsum, sum;
    m = clamp_size(win_rows_q, MaxWindow);
    n = clamp_size(win_cols_q, MaxWindow);
    w = clamp_size(img_w_q, MaxWidth);
    h = clamp_size(img_h_q, HeightLimit);
    got = 1'b0;
    res = '0;
    colsum = pix;
    if (row_pos + 1 >= m) begin
      for (int unsigned k = 1; k < m; k++) colsum += line_mem[(row_pos - k) % StoreRows][col_pos];
    end
    for (int unsigned k = MaxWindow - 1; k > 0; k--) col_sums[k] = col_sums[k - 1];
    col_sums[0] = colsum;
    line_mem[row_pos % StoreRows][col_pos] = pix;
    if (row_pos + 1 >= m && col_pos + 1 >= n && m <= h && n <= w) begin
      sum = 0;
      for (int unsigned k = 0; k < n; k++) sum += col_sums[k];
      res.average = PixW'(sum / (m * n));
      res.last    = (row_pos + 1 == h) && (col_pos + 1 == w);
      got = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Leaves cfg_we_i high; the caller lowers it after the last write of a group.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CfgWinRows: win_rows_q = data[WinRegW-1:0];
      CfgWinCols: win_cols_q = data[WinRegW-1:0];
      CfgImgW:    img_w_q    = data;
      default:    img_h_q    = data;
    endcase
    row_pos = 0;
    col_pos = 0;
    reg_writes++;
  endtask

  task automatic feed_pixel(input logic [PixW-1:0] pix, input bit typed, input mean_t typed_mean);
    int unsigned gap;
    bit          got;
    mean_t       res;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    do @(posedge clk_i); while (in_stall_o);
    mean_filter_step(pix, got, res);
    if (typed) pending_means.push_back(typed_mean);
    else if (got) pending_means.push_back(res);
    pixels_sent++;
  endtask

  // The last pixel may still be in flight without a result, so wait out the latency too.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Window code: mostly the wanted size, sometimes zero, oversized or with junk above bit 3.
  function automatic logic [CfgDataW-1:0] window_code(int unsigned want);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return CfgDataW'($urandom_range(9, 15));
    if (pick == 2) return {7'($urandom_range(1, 127)), 4'(want)};
    return CfgDataW'(want);
  endfunction

  // Result side: after each transfer it draws how many cycles the next result is held off.
  always @(posedge clk_i) begin : take_means
    mean_t       front;
    int unsigned hold;
    if (out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected average %0d last %0b", $time, average_o, last_o);
        fault_count++;
      end else begin
        front = pending_means.pop_front();
        if (average_o !== front.average) begin
          $display("%0t: average expected %0d got %0d", $time, front.average, average_o);
          fault_count++;
        end
        if (last_o !== front.last) begin
          $display("%0t: last expected %0b got %0b", $time, front.last, last_o);
          fault_count++;
        end
        means_checked++;
      end
      hold = $urandom_range(0, out_wait_max);
      wait_left   <= hold;
      out_stall_i <= (hold != 0);
    end else if (out_valid_o && wait_left != 0) begin
      wait_left   <= wait_left - 1;
      out_stall_i <= (wait_left > 1);
    end
  end

  initial begin
    bit                  writing;
    int unsigned         rand_start, m_e, n_e, w_e, h_e, count, mode;
    logic [CfgDataW-1:0] m_raw, n_raw, w_raw, h_raw;
    logic [PixW-1:0]     p;
    writing = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PlanLen; i++) begin
      if (Plan[i].kind == RowCfg) begin
        if (!writing) begin
          settle();
          setups++;
        end
        cfg_write(Plan[i].idx, Plan[i].data);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we_i <= 1'b0;
          writing = 1'b0;
        end
        feed_pixel(Plan[i].pix, Plan[i].kind == RowPixExp, mean_t'{Plan[i].avg, Plan[i].lst});
      end
    end

    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RandPixels) begin
      settle();
      setups++;
      m_raw = window_code(($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4));
      n_raw = window_code(($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4));
      m_e = clamp_size(m_raw[WinRegW-1:0], MaxWindow);
      n_e = clamp_size(n_raw[WinRegW-1:0], MaxWindow);
      if ($urandom_range(0, 9) == 0) begin
        // Very wide or very tall image: only the start of the frame is sent.
        if ($urandom_range(0, 1) == 1) begin
          w_raw = CfgDataW'($urandom_range(1024, 2047));
          h_raw = CfgDataW'($urandom_range(1, 3));
        end else begin
          w_raw = CfgDataW'($urandom_range(1, n_e + 4));
          h_raw = CfgDataW'($urandom_range(1024, 2047));
        end
        count = $urandom_range(20, 60);
      end else begin
        w_raw = ($urandom_range(0, 7) == 0) ? CfgDataW'($urandom_range(0, n_e))
                                            : CfgDataW'(n_e + $urandom_range(0, 5));
        h_raw = ($urandom_range(0, 7) == 0) ? CfgDataW'($urandom_range(0, m_e))
                                            : CfgDataW'(m_e + $urandom_range(0, 3));
        w_e = clamp_size(w_raw, MaxWidth);
        h_e = clamp_size(h_raw, HeightLimit);
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w_e * h_e)
                                            : $urandom_range(1, 2) * w_e * h_e;
      end
      // The last setup sends only what is left of the pixel budget.
      if (count > RandPixels - (pixels_sent - rand_start)) begin
        count = RandPixels - (pixels_sent - rand_start);
      end
      cfg_write(CfgWinRows, m_raw);
      cfg_write(CfgWinCols, n_raw);
      cfg_write(CfgImgW, w_raw);
      cfg_write(CfgImgH, h_raw);
      cfg_we_i <= 1'b0;
      in_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 15;
      out_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      mode = $urandom_range(0, 3);
      for (int unsigned k = 0; k < count; k++) begin
        case (mode)
          1:       p = PixW'($urandom_range(240, 255));
          2:       p = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
          default: p = PixW'($urandom_range(0, 255));
        endcase
        feed_pixel(p, 1'b0, '0);
      end
    end

    settle();
    $display("tb: %0d pixels over %0d setups, %0d register writes", pixels_sent, setups,
             reg_writes);
    $display("tb: %0d averages checked, %0d mismatches", means_checked, fault_count);
    if (fault_count == 0 && pending_means.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb: timeout with %0d averages outstanding", pending_means.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
